[sv/tsbb_pkg.sv]
// shared types and constants for the texture sampler
package tsbb_pkg;
	localparam logic [1:0] ACT_WRITE    = 2'd0;
	localparam logic [1:0] ACT_NEAREST  = 2'd1;
	localparam logic [1:0] ACT_BILINEAR = 2'd2;
	localparam logic [1:0] ACT_BOX      = 2'd3;
	localparam int COORD_BITS = 17;
	localparam int OUT_BITS   = 16;
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;
endpackage

[sv/tsbb_div.sv]
// restoring divider, one quotient bit per cycle
module tsbb_div import tsbb_pkg::*; #(
	parameter int NUM_BITS = 38,
	parameter int DEN_BITS = 21
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [NUM_BITS-1:0] quo
);
	localparam int CW = $clog2(NUM_BITS + 1);
	logic [CW-1:0]       cnt_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS:0]   shifted;
	logic [DEN_BITS:0]   diff;
	logic                busy_q;
	logic                done_q;

	assign shifted = {rem_q[DEN_BITS-1:0], quo_q[NUM_BITS-1]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_BITS]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[sv/tsbb_blend.sv]
// shared blend unit: (a*(one-f) + b*f) >> frac
module tsbb_blend import tsbb_pkg::*; #(
	parameter int CH_BITS = 16,
	parameter int FRAC    = 8
) (
	input  logic               clk,
	input  logic [CH_BITS-1:0] a,
	input  logic [CH_BITS-1:0] b,
	input  logic [FRAC-1:0]    f,
	output logic [CH_BITS-1:0] y
);
	logic [CH_BITS+FRAC:0] pa_s1;
	logic [CH_BITS+FRAC:0] pb_s1;
	logic [FRAC:0]         one_minus;
	logic [CH_BITS+FRAC+1:0] sum;

	assign one_minus = (FRAC+1)'(1) << FRAC;

	always_ff @(posedge clk) begin
		pa_s1 <= (CH_BITS+FRAC+1)'(a) * (one_minus - (FRAC+1)'(f));
		pb_s1 <= (CH_BITS+FRAC+1)'(b) * (CH_BITS+FRAC+1)'(f);
	end

	assign sum = (CH_BITS+FRAC+2)'(pa_s1) + (CH_BITS+FRAC+2)'(pb_s1);
	assign y   = sum[FRAC +: CH_BITS];
endmodule

[sv/texture_sampler_bilinear_box_core.sv]
// texture sampler top level: store, sequencer, blend unit and divider
// A write stores its texel from the write state and returns to idle. Nearest passes
// through the read, wait and nearest states to the output state; an out-of-range query
// goes straight to the output state. Bilinear reads its four texels from the
// single-port store one per cycle and runs nine blends, one after another, through one
// shared blend unit whose products are registered. Box average reads one texel a cycle
// over the rectangle, then divides each channel by the area in a shared bit-serial
// divider as wide as CHANNEL_BITS plus the address bits (30 by default), one channel
// after another. The store is not cleared; a texel must be written before it is read.
// A result waits in an output register until taken; the next request is accepted
// meanwhile and its own result is held back until the register is free.
module texture_sampler_bilinear_box_core import tsbb_pkg::*; #(
	parameter int MAX_WIDTH    = 128,
	parameter int MAX_HEIGHT   = 128,
	parameter int FRAC_BITS    = 8,
	parameter int CHANNEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // x_pos, y_pos, x_end, y_end, red_in, green_in, blue_in
	input  logic [1:0]  s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // red_out, green_out, blue_out
	output logic        m_axis_tuser,   // position_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	localparam int XB = $clog2(MAX_WIDTH);
	localparam int YB = $clog2(MAX_HEIGHT);
	localparam int AB = XB + YB;
	localparam int DEPTH = 1 << AB;
	localparam int CB = CHANNEL_BITS;
	localparam int SB = CB + AB;
	localparam int DB = AB + 2;
	localparam int IB = COORD_BITS - FRAC_BITS + 1;
	localparam int WB = 11;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WRITE = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_WAIT  = 4'd3;
	localparam logic [3:0] ST_NEAR  = 4'd4;
	localparam logic [3:0] ST_BLEND = 4'd5;
	localparam logic [3:0] ST_BSUM  = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0] state_q;
	logic [7:0] width_q, height_q;
	logic [1:0] act_q;
	logic signed [COORD_BITS-1:0] xp_q, yp_q, xe_q, ye_q;
	logic [3*CB-1:0] wcol_q;
	logic [3*CB-1:0] mem [DEPTH];
	logic [3*CB-1:0] rd_q;
	logic [AB-1:0] addr;
	logic [WB-1:0] w_eff, h_eff;

	logic signed [COORD_BITS-1:0] xp, yp, xe, ye;
	assign xp = s_axis_tdata[16:0];
	assign yp = s_axis_tdata[33:17];
	assign xe = s_axis_tdata[50:34];
	assign ye = s_axis_tdata[67:51];

	function automatic logic signed [IB-1:0] trunc_c(input logic signed [COORD_BITS-1:0] v);
		logic signed [COORD_BITS-1:0] m;
		logic signed [COORD_BITS:0] a;
		begin
			m = v;
			a = (v < 0) ? -(COORD_BITS+1)'(v) : (COORD_BITS+1)'(v);
			a = a >>> FRAC_BITS;
			trunc_c = (m < 0) ? -IB'(a) : IB'(a);
		end
	endfunction

	assign w_eff = (WB'(width_q) < WB'(MAX_WIDTH)) ? WB'(width_q) : WB'(MAX_WIDTH);
	assign h_eff = (WB'(height_q) < WB'(MAX_HEIGHT)) ? WB'(height_q) : WB'(MAX_HEIGHT);

	// coordinates held in registers
	logic signed [IB-1:0] x1_q, x2_q, y2_q;
	logic [XB-1:0] cx_q;
	logic [YB-1:0] cy_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic err_q;
	logic [1:0] rcnt_q;
	logic [3*CB-1:0] t_q [4];
	logic [3:0] bstep_q;
	logic [CB-1:0] bot_q [3];
	logic [CB-1:0] res_q [3];
	logic [SB-1:0] sum_q [3];
	logic [DB-1:0] area_q;
	logic [1:0] dch_q;
	logic sum_last_q;
	logic rd_pend_q;

	// blend unit operand selection
	logic [CB-1:0] ba, bb, by;
	logic [FRAC_BITS-1:0] bf;
	logic [1:0] bch;
	logic [1:0] bkind;
	always_comb begin
		case (bstep_q) inside
			4'd1, 4'd4, 4'd7: bch = 2'd1;
			4'd2, 4'd5, 4'd8: bch = 2'd2;
			default:          bch = 2'd0;
		endcase
	end
	assign bkind = (bstep_q < 4'd3) ? 2'd0 : (bstep_q < 4'd6) ? 2'd1 : 2'd2;
	always_comb begin
		case (bkind)
			2'd0: begin
				ba = t_q[0][bch*CB +: CB];
				bb = t_q[1][bch*CB +: CB];
				bf = fx_q;
			end
			2'd1: begin
				ba = t_q[2][bch*CB +: CB];
				bb = t_q[3][bch*CB +: CB];
				bf = fx_q;
			end
			default: begin
				ba = bot_q[bch];
				bb = res_q[bch];
				bf = fy_q;
			end
		endcase
	end
	tsbb_blend #(.CH_BITS(CB), .FRAC(FRAC_BITS)) u_blend (
		.clk(clk), .a(ba), .b(bb), .f(bf), .y(by));

	logic [3:0] bres_step_q;
	logic bres_v_q;

	// divider
	logic div_start, div_done;
	logic [SB-1:0] div_quo;
	tsbb_div #(.NUM_BITS(SB), .DEN_BITS(DB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sum_q[dch_q]),
		.den(area_q), .done(div_done), .quo(div_quo));
	logic div_go_q;
	assign div_start = div_go_q;

	// address
	always_comb begin
		addr = {cy_q, cx_q};
		if (state_q == ST_READ && act_q == ACT_BILINEAR) begin
			addr = {YB'(cy_q + YB'(rcnt_q[1])), XB'(cx_q + XB'(rcnt_q[0]))};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && !err_q) begin
			mem[addr] <= wcol_q;
		end
		rd_q <= mem[addr];
	end

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	logic signed [IB-1:0] nx, ny, lx, hx, ly, hy;
	assign nx = trunc_c(xp);
	assign ny = trunc_c(yp);
	assign lx = trunc_c((xp < xe) ? xp : xe);
	assign hx = trunc_c((xp < xe) ? xe : xp);
	assign ly = trunc_c((yp < ye) ? yp : ye);
	assign hy = trunc_c((yp < ye) ? ye : yp);

	logic signed [IB:0] wlim, hlim;
	assign wlim = (IB+1)'(w_eff);
	assign hlim = (IB+1)'(h_eff);

	logic n_err, bl_err, bx_err, q_err;
	assign n_err = nx < 0 || (IB+1)'(nx) >= wlim || ny < 0 || (IB+1)'(ny) >= hlim;
	assign bl_err = xp < 0 || yp < 0 || w_eff < WB'(2) || h_eff < WB'(2)
		|| (IB+1)'(xp >>> FRAC_BITS) >= wlim - 1 || (IB+1)'(yp >>> FRAC_BITS) >= hlim - 1;
	assign bx_err = lx < 0 || ly < 0 || (IB+1)'(hx) >= wlim || (IB+1)'(hy) >= hlim;
	always_comb begin
		unique case (s_axis_tuser)
			ACT_NEAREST:  q_err = n_err;
			ACT_BILINEAR: q_err = bl_err;
			ACT_BOX:      q_err = bx_err;
			default:      q_err = n_err;
		endcase
	end

	logic [DB-1:0] area_w;
	assign area_w = DB'(DB'(hx - lx + 1) * DB'(hy - ly + 1));

	logic out_v_q;
	logic [CB-1:0] o_q [3];
	logic oerr_q;
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= 8'd128;
			height_q <= 8'd128;
			out_v_q  <= 1'b0;
			rcnt_q   <= '0;
			bstep_q  <= '0;
			bres_v_q <= 1'b0;
			div_go_q <= 1'b0;
			rd_pend_q <= 1'b0;
			sum_last_q <= 1'b0;
			dch_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					rcnt_q <= '0;
					bstep_q <= '0;
					if (s_axis_tuser == ACT_WRITE) state_q <= ST_WRITE;
					else if (q_err) state_q <= ST_OUT;
					else if (s_axis_tuser == ACT_BOX) state_q <= ST_BSUM;
					else state_q <= ST_READ;
					rd_pend_q <= 1'b0;
					sum_last_q <= 1'b0;
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_READ: begin
					rcnt_q <= rcnt_q + 1'b1;
					if (act_q == ACT_NEAREST) state_q <= ST_WAIT;
					else if (rcnt_q == 2'd3) state_q <= ST_WAIT;
				end
				ST_WAIT: state_q <= (act_q == ACT_NEAREST) ? ST_NEAR : ST_BLEND;
				ST_NEAR: state_q <= ST_OUT;
				ST_BLEND: begin
					bres_v_q <= 1'b0;
					if (bstep_q != 4'd9 && !bres_v_q) begin
						bstep_q <= bstep_q;
					end
					if (bres_v_q && bres_step_q == 4'd8) state_q <= ST_OUT;
					else if (!bres_v_q && bstep_q < 4'd9) begin
						bres_v_q <= 1'b1;
					end
					if (bres_v_q) bstep_q <= bstep_q + 1'b1;
				end
				ST_BSUM: begin
					rd_pend_q <= !sum_last_q;
					if (!sum_last_q && cx_q == XB'(x2_q) && cy_q == YB'(y2_q))
						sum_last_q <= 1'b1;
					if (rd_pend_q && sum_last_q) begin
						state_q <= ST_DIV;
						dch_q <= '0;
						div_go_q <= 1'b1;
					end
				end
				ST_DIV: if (div_done) begin
					if (dch_q == 2'd2) state_q <= ST_OUT;
					else begin
						dch_q <= dch_q + 1'b1;
						div_go_q <= 1'b1;
					end
				end
				ST_OUT: if (out_load) begin
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		bres_step_q <= bstep_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				act_q <= s_axis_tuser;
				wcol_q <= {CB'(s_axis_tdata[100 +: 16]), CB'(s_axis_tdata[84 +: 16]),
					CB'(s_axis_tdata[68 +: 16])};
				err_q <= (s_axis_tuser == ACT_WRITE) ? n_err : q_err;
				if (s_axis_tuser == ACT_BOX) begin
					cx_q <= XB'(lx); cy_q <= YB'(ly);
					x1_q <= lx; x2_q <= hx; y2_q <= hy;
					area_q <= area_w;
				end else if (s_axis_tuser == ACT_BILINEAR) begin
					cx_q <= XB'(xp >>> FRAC_BITS); cy_q <= YB'(yp >>> FRAC_BITS);
				end else begin
					cx_q <= XB'(nx); cy_q <= YB'(ny);
				end
				fx_q <= xp[FRAC_BITS-1:0];
				fy_q <= yp[FRAC_BITS-1:0];
				for (int c = 0; c < 3; c++) sum_q[c] <= '0;
			end
			ST_READ: if (rcnt_q != 2'd0) t_q[rcnt_q - 1'b1] <= rd_q;
			ST_WAIT: t_q[3] <= rd_q;
			ST_NEAR: for (int c = 0; c < 3; c++) res_q[c] <= rd_q[c*CB +: CB];
			ST_BLEND: if (bres_v_q) begin
				if (bres_step_q < 4'd3) bot_q[bch] <= by;
				else if (bres_step_q < 4'd6) res_q[bch] <= by;
				else res_q[bch] <= by;
			end
			ST_BSUM: begin
				if (rd_pend_q)
					for (int c = 0; c < 3; c++)
						sum_q[c] <= sum_q[c] + SB'(rd_q[c*CB +: CB]);
				if (!sum_last_q) begin
					if (cx_q == XB'(x2_q)) begin
						cx_q <= XB'(x1_q);
						cy_q <= cy_q + 1'b1;
					end else cx_q <= cx_q + 1'b1;
				end
			end
			ST_DIV: if (div_done) res_q[dch_q] <= CB'(div_quo);
			default: ;
		endcase
		if (out_load) begin
			for (int c = 0; c < 3; c++) o_q[c] <= err_q ? '0 : res_q[c];
			oerr_q <= err_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {OUT_BITS'(o_q[2]), OUT_BITS'(o_q[1]), OUT_BITS'(o_q[0])};
	assign m_axis_tuser  = oerr_q;
endmodule

[sv/tsbb_checker.sv]
// port-level checker for the texture sampler, bound to the top level
module tsbb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic       m_axis_tuser
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("error result not zero");
	a_user_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
		else $error("error flag changed while waiting");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready during work");
endmodule

bind texture_sampler_bilinear_box_core tsbb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));

[tb/tb.sv]
// self-checking testbench for the texture sampler: texel writes, queries, size settings
module tb;
	import tsbb_pkg::*;

	typedef struct {
		logic [1:0]  act;
		int          xp, yp, xe, ye;
		logic [15:0] red, green, blue;
	} request_t;

	typedef struct {
		logic [15:0] red, green, blue;
		logic        err;
	} colour_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = ACT_WRITE;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [47:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_index = CFG_WIDTH;
	logic [7:0]   cfg_data = '0;

	texture_sampler_bilinear_box_core i_dut (.*);

	always #10 clk = ~clk;

	// texture copy and settings as seen by the sampler
	logic [47:0] texels [16384];
	bit          texel_valid [16384];
	int          size_w = 128, size_h = 128;

	request_t pending [$];
	colour_t  expected_colours [$];
	int       fail_count = 0;
	int       send_idle = 0, recv_idle = 0;
	bit       hold_arm = 0, hold_seen = 0;
	int       hold_cnt = 0;
	int       quiet_cycles = 0;
	request_t drv_req;
	colour_t  got;

	function automatic int trunc_fx(int v);
		return v >= 0 ? v >>> 8 : -((-v) >>> 8);
	endfunction

	function automatic int used_w();
		return size_w > 128 ? 128 : size_w;
	endfunction

	function automatic int used_h();
		return size_h > 128 ? 128 : size_h;
	endfunction

	function automatic longint blend(longint a, longint b, longint f);
		return (a * (256 - f) + b * f) >>> 8;
	endfunction

	function automatic logic [47:0] rand_colour();
		return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535))};
	endfunction

	// apply one request to the texture copy, queue it for sending and, for a query, queue its colour
	task automatic sample_push(request_t r);
		int          w, h, x1, x2, y1, y2, x, y, c;
		bit          err;
		longint      sum [3];
		longint      area;
		logic [47:0] bl, br, tl, tr;
		request_t    wr;
		colour_t     res;
		w = used_w();
		h = used_h();
		err = 0;
		x1 = 0; x2 = 0; y1 = 0; y2 = 0;
		case (r.act)
			ACT_WRITE: begin
				x = trunc_fx(r.xp);
				y = trunc_fx(r.yp);
				if (x >= 0 && x < w && y >= 0 && y < h) begin
					texels[x + y * 128] = {r.blue, r.green, r.red};
					texel_valid[x + y * 128] = 1;
				end
				pending.push_back(r);
				return;
			end
			ACT_NEAREST: begin
				x1 = trunc_fx(r.xp); y1 = trunc_fx(r.yp);
				x2 = x1; y2 = y1;
				err = x1 < 0 || x1 >= w || y1 < 0 || y1 >= h;
			end
			ACT_BILINEAR: begin
				err = r.xp < 0 || r.xp >= (w - 1) * 256 || r.yp < 0 || r.yp >= (h - 1) * 256;
				x1 = r.xp >>> 8; y1 = r.yp >>> 8;
				x2 = x1 + 1; y2 = y1 + 1;
			end
			default: begin
				x1 = trunc_fx(r.xp < r.xe ? r.xp : r.xe);
				x2 = trunc_fx(r.xp < r.xe ? r.xe : r.xp);
				y1 = trunc_fx(r.yp < r.ye ? r.yp : r.ye);
				y2 = trunc_fx(r.yp < r.ye ? r.ye : r.yp);
				err = x1 < 0 || x2 >= w || y1 < 0 || y2 >= h;
			end
		endcase
		res = '{default: '0};
		res.err = err;
		if (!err) begin
			// texels are written before any query reads them
			for (y = y1; y <= y2; y++)
				for (x = x1; x <= x2; x++)
					if (!texel_valid[x + y * 128]) begin
						wr.act = ACT_WRITE;
						wr.xp = x * 256 + $urandom_range(0, 255);
						wr.yp = y * 256 + $urandom_range(0, 255);
						wr.xe = $urandom_range(0, 131071) - 65536;
						wr.ye = $urandom_range(0, 131071) - 65536;
						{wr.blue, wr.green, wr.red} = rand_colour();
						sample_push(wr);
					end
			if (r.act == ACT_BILINEAR) begin
				bl = texels[x1 + y1 * 128]; br = texels[x2 + y1 * 128];
				tl = texels[x1 + y2 * 128]; tr = texels[x2 + y2 * 128];
				for (c = 0; c < 3; c++)
					sum[c] = blend(blend(bl[16*c +: 16], br[16*c +: 16], r.xp & 255),
						blend(tl[16*c +: 16], tr[16*c +: 16], r.xp & 255), r.yp & 255);
			end else begin
				sum = '{0, 0, 0};
				for (y = y1; y <= y2; y++)
					for (x = x1; x <= x2; x++)
						for (c = 0; c < 3; c++)
							sum[c] += texels[x + y * 128][16*c +: 16];
				area = longint'(x2 - x1 + 1) * (y2 - y1 + 1);
				for (c = 0; c < 3; c++)
					sum[c] = sum[c] / area;
			end
			res.red = sum[0][15:0];
			res.green = sum[1][15:0];
			res.blue = sum[2][15:0];
		end
		pending.push_back(r);
		expected_colours.push_back(res);
	endtask

	task automatic add(logic [1:0] act, int xp, int yp, int xe = 0, int ye = 0,
			logic [47:0] col = 48'h0);
		request_t r;
		r.act = act;
		r.xp = xp; r.yp = yp; r.xe = xe; r.ye = ye;
		{r.blue, r.green, r.red} = col;
		sample_push(r);
	endtask

	function automatic int noise_coord();
		return $urandom_range(0, 131071) - 65536;
	endfunction

	// coordinate mostly in a small corner, sometimes over the whole used size
	function automatic int coord(int lim);
		int span;
		span = lim;
		if (span > 10 && $urandom_range(0, 7) != 0)
			span = 10;
		return $urandom_range(0, span * 256 + 40) - 20;
	endfunction

	task automatic random_requests(int n);
		int       k, sel, xp, yp, xe, ye, w, h;
		request_t r;
		w = used_w();
		h = used_h();
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			xp = coord(w); yp = coord(h);
			xe = xp + $urandom_range(0, 1280) - 640;
			ye = yp + $urandom_range(0, 1280) - 640;
			if (sel < 10) begin
				xp = noise_coord(); yp = noise_coord();
				xe = noise_coord(); ye = noise_coord();
				// keep accidental large boxes narrow
				if (trunc_fx(xp) - trunc_fx(xe) > 8 || trunc_fx(xe) - trunc_fx(xp) > 8)
					xe = xp;
				if (trunc_fx(yp) - trunc_fx(ye) > 8 || trunc_fx(ye) - trunc_fx(yp) > 8)
					ye = yp;
			end
			if (sel < 35 && sel >= 10)
				add(ACT_WRITE, xp, yp, xe, ye, rand_colour());
			else
				add(logic'(2'($urandom_range(0, 3))) == 0 ? ACT_WRITE
					: 2'($urandom_range(1, 3)), xp, yp, xe, ye, rand_colour());
		end
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_WIDTH)
			size_w = val;
		else
			size_h = val;
	endtask

	task automatic drain();
		while (pending.size() != 0 || s_axis_tvalid || expected_colours.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				drv_req = pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= drv_req.act;
				s_axis_tdata <= {4'b0, drv_req.blue, drv_req.green, drv_req.red,
					17'(drv_req.ye), 17'(drv_req.xe), 17'(drv_req.yp), 17'(drv_req.xp)};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready, with the long hold-off counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_arm != hold_seen) begin
			hold_seen <= hold_arm;
			hold_cnt <= 400;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(0, 99) >= recv_idle;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_colours.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				got = expected_colours.pop_front();
				if (m_axis_tdata[15:0] !== got.red) begin
					$error("red_out expected %0h got %0h", got.red, m_axis_tdata[15:0]);
					fail_count++;
				end
				if (m_axis_tdata[31:16] !== got.green) begin
					$error("green_out expected %0h got %0h", got.green, m_axis_tdata[31:16]);
					fail_count++;
				end
				if (m_axis_tdata[47:32] !== got.blue) begin
					$error("blue_out expected %0h got %0h", got.blue, m_axis_tdata[47:32]);
					fail_count++;
				end
				if (m_axis_tuser !== got.err) begin
					$error("position_error expected %0b got %0b", got.err, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 200000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int sizes [8][2];
		int p;
		sizes = '{'{128, 128}, '{2, 2}, '{128, 128}, '{255, 200}, '{1, 7}, '{0, 0},
			'{16, 9}, '{40, 128}};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 38;
		recv_idle = 61;
		// corners, extreme colours and every query kind
		add(ACT_WRITE, 0, 0, 0, 0, 48'h0);
		add(ACT_WRITE, 127 * 256 + 255, 127 * 256 + 255, -65536, 65535, 48'hffff_ffff_ffff);
		add(ACT_NEAREST, 0, 0);
		add(ACT_NEAREST, 127 * 256 + 255, 127 * 256 + 255);
		add(ACT_NEAREST, -255, -1);
		add(ACT_NEAREST, -256, 0);
		add(ACT_NEAREST, 128 * 256, 0);
		add(ACT_NEAREST, 65535, -65536);
		add(ACT_WRITE, -65536, 65535, 0, 0, 48'h1234_5678_9abc);
		add(ACT_BILINEAR, 0, 0);
		add(ACT_BILINEAR, 255, 255);
		add(ACT_BILINEAR, 126 * 256 + 255, 126 * 256 + 255);
		add(ACT_BILINEAR, 127 * 256, 0);
		add(ACT_BILINEAR, -1, 0);
		add(ACT_BOX, 3 * 256 + 9, 2 * 256, 0, 0);
		add(ACT_BOX, 0, 0, 0, 0);
		add(ACT_BOX, 127 * 256 + 255, 125 * 256, 124 * 256, 127 * 256 + 255);
		add(ACT_BOX, -300, 0, 256, 256);
		add(ACT_BOX, 0, 0, 128 * 256, 256);
		add(ACT_BOX, -65536, -65536, 65535, 65535);
		random_requests(80);
		drain();
		for (p = 1; p < 8; p++) begin
			send_idle = p < 3 ? 38 : p < 6 ? 61 : 0;
			recv_idle = p < 3 ? 61 : p < 6 ? 38 : 0;
			write_reg(CFG_WIDTH, 8'(sizes[p][0]));
			write_reg(CFG_HEIGHT, 8'(sizes[p][1]));
			if (p == 6)
				hold_arm = ~hold_arm;
			random_requests(90);
			drain();
		end
		if (fail_count == 0 && expected_colours.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
